FILE: rtl/fse_pkg.sv
// Package for the fan sweep evaluator: field widths, register indexes,
// reset values, the arithmetic unit control struct and small helpers.
// No dependencies; imported by every module of the block.
package fse_pkg;

    // Field widths
    localparam int RPM_W  = 16;
    localparam int PCT_W  = 7;
    localparam int PPR_W  = 3;
    localparam int CIDX_W = 3;

    // Serial arithmetic: products and dividends fit in 23 bits, the span
    // quotient never exceeds 100 and so fits in 7 bits.
    localparam int ACC_W       = 23;
    localparam int STEPS       = 7;
    localparam int CNT_W       = 3;
    localparam int DIV_SHIFT   = STEPS - 1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ASSUMED_PPR   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MONO_TOL      = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FLAT_MIN_SPAN = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_PLAUS_MIN     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PLAUS_MAX     = 3'd4;

    // Configuration reset values
    localparam logic [PPR_W-1:0] RST_ASSUMED_PPR   = 3'd2;
    localparam logic [PCT_W-1:0] RST_MONO_TOL      = 7'd3;
    localparam logic [PCT_W-1:0] RST_FLAT_MIN_SPAN = 7'd10;
    localparam logic [RPM_W-1:0] RST_PLAUS_MIN     = 16'd300;
    localparam logic [RPM_W-1:0] RST_PLAUS_MAX     = 16'd30000;

    // Run state reset value and limits
    localparam logic [RPM_W-1:0] RPM_MAX_VAL = 16'hFFFF;
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PPR_W-1:0] PPR_LO      = 3'd1;
    localparam logic [PPR_W-1:0] PPR_HI      = 3'd4;

    // Control of the shared serial arithmetic unit
    typedef struct packed {
        logic load_mul;
        logic load_div;
        logic step;
    } fse_arith_ctrl_t;

    // Multiply by one hundred with shifts and adds: 64 + 32 + 4.
    function automatic logic [ACC_W:0] times_hundred(input logic [RPM_W:0] v);
        logic [ACC_W:0] w;
        begin
            w = {{(ACC_W-RPM_W){1'b0}}, v};
            return (w << 6) + (w << 5) + (w << 2);
        end
    endfunction

endpackage

FILE: rtl/fse_arith.sv
// Shared bit-serial arithmetic unit: shift-and-add multiply and
// restoring shift-and-subtract divide, one bit per clock.
// Depends on fse_pkg.
module fse_arith
    import fse_pkg::*;
(
    input  logic                 clk,
    input  fse_arith_ctrl_t      ctrl,
    input  logic [RPM_W-1:0]     mul_a,
    input  logic [PCT_W-1:0]     mul_b,
    input  logic [ACC_W-1:0]     div_num,
    input  logic [RPM_W-1:0]     div_den,
    output logic [ACC_W-1:0]     product,
    output logic [STEPS-1:0]     quotient
);

    logic [ACC_W-1:0] acc_reg,  acc_next;
    logic [ACC_W-1:0] opnd_reg, opnd_next;
    logic [STEPS-1:0] bits_reg, bits_next;
    logic             div_mode_reg, div_mode_next;
    logic             fits;

    // One iteration: multiply takes the multiplier MSB first, divide
    // produces one quotient bit against a right-shifting divisor.
    always_comb
    begin
        acc_next      = acc_reg;
        opnd_next     = opnd_reg;
        bits_next     = bits_reg;
        div_mode_next = div_mode_reg;
        fits          = (acc_reg >= opnd_reg);
        if (ctrl.load_mul)
        begin
            acc_next      = '0;
            opnd_next     = {{(ACC_W-RPM_W){1'b0}}, mul_a};
            bits_next     = mul_b;
            div_mode_next = 1'b0;
        end
        else if (ctrl.load_div)
        begin
            acc_next      = div_num;
            opnd_next     = {{(ACC_W-RPM_W){1'b0}}, div_den} << DIV_SHIFT;
            bits_next     = '0;
            div_mode_next = 1'b1;
        end
        else if (ctrl.step)
        begin
            if (div_mode_reg)
            begin
                if (fits)
                begin
                    acc_next = acc_reg - opnd_reg;
                end
                bits_next = {bits_reg[STEPS-2:0], fits};
                opnd_next = opnd_reg >> 1;
            end
            else
            begin
                acc_next  = (acc_reg << 1) + (bits_reg[STEPS-1] ? opnd_reg : '0);
                bits_next = bits_reg << 1;
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        opnd_reg     <= opnd_next;
        bits_reg     <= bits_next;
        div_mode_reg <= div_mode_next;
    end

    assign product  = acc_reg;
    assign quotient = bits_reg;

endmodule

FILE: rtl/fan_sweep_evaluator.sv
// Fan sweep evaluator: judges one duty sweep of a fan from a run of speed
// readings and reports monotonicity, span, score and a ppr suggestion.
// Depends on fse_pkg and fse_arith.
//
// The input channel (in_valid/in_ready) carries one speed reading per
// transaction with its valid flag and a last-of-run mark; a reading with
// reading_valid low counts as zero speed. Only the reading marked last
// produces a result transaction on the output channel (out_valid/out_ready).
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes
// the register at cfg_index with cfg_data; unused indexes are ignored.
// An ordinary reading occupies the block through its acceptance, a serial
// multiply for the monotonic floor in ST_MUL and the update in ST_TEST.
// A last reading adds a serial division of the span by the highest speed
// in ST_DIV and the loading of the result in ST_FIN. Both the multiply and
// the division run in the shared arithmetic unit.
// The result sits in an output register, so the next run can start while it
// waits. If the receiver stalls and the register is still full when the next
// result is ready, the block holds that result and takes no new reading until
// the register frees. Reset clears the run state and loads the default setup.
module fan_sweep_evaluator
    import fse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [RPM_W-1:0]   sample_rpm,
    input  logic               reading_valid,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_monotonic,
    output logic [PCT_W-1:0]   span_percent,
    output logic [PCT_W-1:0]   run_score,
    output logic               degenerate,
    output logic [RPM_W-1:0]   lowest_running_rpm,
    output logic [RPM_W-1:0]   final_rpm,
    output logic [PPR_W-1:0]   ppr_advice,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [RPM_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_TEST = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } fse_state_t;

    fse_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Configuration registers
    logic [PPR_W-1:0] ppr_cfg_reg;
    logic [PCT_W-1:0] tol_cfg_reg;
    logic [PCT_W-1:0] flat_cfg_reg;
    logic [RPM_W-1:0] pmin_cfg_reg;
    logic [RPM_W-1:0] pmax_cfg_reg;

    // Run state
    logic [RPM_W-1:0] prev_reg, prev_next;
    logic [RPM_W-1:0] lo_reg, lo_next;
    logic [RPM_W-1:0] hi_reg, hi_next;
    logic [RPM_W-1:0] lnz_reg, lnz_next;
    logic             seen_reg, seen_next;
    logic             mono_reg, mono_next;
    logic             first_reg, first_next;

    // Current reading
    logic [RPM_W-1:0] rpm_reg, rpm_next;
    logic             last_reg, last_next;

    // Output register
    logic             ovld_reg, ovld_next;
    logic             omono_reg, omono_next;
    logic [PCT_W-1:0] ospan_reg, ospan_next;
    logic [PCT_W-1:0] oscore_reg, oscore_next;
    logic             odegen_reg, odegen_next;
    logic [RPM_W-1:0] olnz_reg, olnz_next;
    logic [RPM_W-1:0] ofinal_reg, ofinal_next;
    logic [PPR_W-1:0] oppr_reg, oppr_next;

    // Arithmetic unit connections
    fse_arith_ctrl_t  actrl;
    logic [PCT_W-1:0] tol_clamped;
    logic [PCT_W-1:0] mul_b;
    logic [ACC_W:0]   span_scaled;
    logic [ACC_W-1:0] div_num;
    logic [ACC_W-1:0] product;
    logic [STEPS-1:0] quotient;

    // Helpers
    logic             in_acc;
    logic             out_free;
    logic             drop_fail;
    logic [ACC_W:0]   rpm_scaled;
    logic [RPM_W-1:0] hi_new, lo_new;
    logic [PCT_W-1:0] span_val;
    logic [PPR_W-1:0] ppr_clamped;
    logic [PPR_W:0]   ppr_double;
    logic [PPR_W-1:0] ppr_half;
    logic [PPR_W-1:0] ppr_sugg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !ovld_reg || out_ready;

    // Multiplier for the monotonic floor: 100 minus the clamped tolerance.
    assign tol_clamped = (tol_cfg_reg > PCT_FULL) ? PCT_FULL : tol_cfg_reg;
    assign mul_b       = PCT_FULL - tol_clamped;

    // rpm < floor(prev*m/100) holds exactly when (rpm+1)*100 <= prev*m.
    assign rpm_scaled = times_hundred({1'b0, rpm_reg} + 17'd1);
    assign drop_fail  = !first_reg && (rpm_scaled <= {1'b0, product});

    // Extremes including the current reading, and the span dividend.
    assign hi_new      = (rpm_reg > hi_reg) ? rpm_reg : hi_reg;
    assign lo_new      = (rpm_reg < lo_reg) ? rpm_reg : lo_reg;
    assign span_scaled = times_hundred({1'b0, hi_new - lo_new});
    assign div_num     = span_scaled[ACC_W-1:0];

    // Span percent from the finished division, zero when nothing turned.
    assign span_val = (hi_reg == '0) ? '0 : quotient;

    // Pulses-per-revolution suggestion from the final speed.
    always_comb
    begin
        if (ppr_cfg_reg < PPR_LO)
        begin
            ppr_clamped = PPR_LO;
        end
        else if (ppr_cfg_reg > PPR_HI)
        begin
            ppr_clamped = PPR_HI;
        end
        else
        begin
            ppr_clamped = ppr_cfg_reg;
        end
        ppr_double = {ppr_clamped, 1'b0};
        ppr_half   = ppr_clamped >> 1;
        if (rpm_reg > pmax_cfg_reg)
        begin
            ppr_sugg = (ppr_double > {1'b0, PPR_HI}) ? PPR_HI : ppr_double[PPR_W-1:0];
        end
        else if (rpm_reg != '0 && rpm_reg < pmin_cfg_reg)
        begin
            ppr_sugg = (ppr_half < PPR_LO) ? PPR_LO : ppr_half;
        end
        else
        begin
            ppr_sugg = ppr_clamped;
        end
    end

    // Sequencer and run state update
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        prev_next   = prev_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        lnz_next    = lnz_reg;
        seen_next   = seen_reg;
        mono_next   = mono_reg;
        first_next  = first_reg;
        rpm_next    = rpm_reg;
        last_next   = last_reg;
        ovld_next   = ovld_reg && !out_ready;
        omono_next  = omono_reg;
        ospan_next  = ospan_reg;
        oscore_next = oscore_reg;
        odegen_next = odegen_reg;
        olnz_next   = olnz_reg;
        ofinal_next = ofinal_reg;
        oppr_next   = oppr_reg;
        actrl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    rpm_next       = reading_valid ? sample_rpm : '0;
                    last_next      = last_sample;
                    actrl.load_mul = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                actrl.step = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (drop_fail)
                begin
                    mono_next = 1'b0;
                end
                lo_next    = lo_new;
                hi_next    = hi_new;
                if (rpm_reg != '0 && (!seen_reg || rpm_reg < lnz_reg))
                begin
                    lnz_next  = rpm_reg;
                    seen_next = 1'b1;
                end
                prev_next  = rpm_reg;
                first_next = 1'b0;
                if (last_reg)
                begin
                    actrl.load_div = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                actrl.step = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Load the result once the output register is free, then
                // rearm for a new run.
                if (out_free)
                begin
                    ovld_next   = 1'b1;
                    omono_next  = mono_reg;
                    ospan_next  = span_val;
                    oscore_next = mono_reg ? span_val : '0;
                    odegen_next = !mono_reg || (span_val < flat_cfg_reg);
                    olnz_next   = seen_reg ? lnz_reg : '0;
                    ofinal_next = rpm_reg;
                    oppr_next   = ppr_sugg;
                    prev_next   = '0;
                    lo_next     = RPM_MAX_VAL;
                    hi_next     = '0;
                    lnz_next    = RPM_MAX_VAL;
                    seen_next   = 1'b0;
                    mono_next   = 1'b1;
                    first_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and run state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            prev_reg  <= '0;
            lo_reg    <= RPM_MAX_VAL;
            hi_reg    <= '0;
            lnz_reg   <= RPM_MAX_VAL;
            seen_reg  <= 1'b0;
            mono_reg  <= 1'b1;
            first_reg <= 1'b1;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            lnz_reg   <= lnz_next;
            seen_reg  <= seen_next;
            mono_reg  <= mono_next;
            first_reg <= first_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_cfg_reg  <= RST_ASSUMED_PPR;
            tol_cfg_reg  <= RST_MONO_TOL;
            flat_cfg_reg <= RST_FLAT_MIN_SPAN;
            pmin_cfg_reg <= RST_PLAUS_MIN;
            pmax_cfg_reg <= RST_PLAUS_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ASSUMED_PPR:   ppr_cfg_reg  <= cfg_data[PPR_W-1:0];
                CFG_MONO_TOL:      tol_cfg_reg  <= cfg_data[PCT_W-1:0];
                CFG_FLAT_MIN_SPAN: flat_cfg_reg <= cfg_data[PCT_W-1:0];
                CFG_PLAUS_MIN:     pmin_cfg_reg <= cfg_data;
                CFG_PLAUS_MAX:     pmax_cfg_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rpm_reg    <= rpm_next;
        last_reg   <= last_next;
        omono_reg  <= omono_next;
        ospan_reg  <= ospan_next;
        oscore_reg <= oscore_next;
        odegen_reg <= odegen_next;
        olnz_reg   <= olnz_next;
        ofinal_reg <= ofinal_next;
        oppr_reg   <= oppr_next;
    end

    // Shared serial multiply and divide
    fse_arith u_arith (
        .clk      (clk),
        .ctrl     (actrl),
        .mul_a    (prev_reg),
        .mul_b    (mul_b),
        .div_num  (div_num),
        .div_den  (hi_new),
        .product  (product),
        .quotient (quotient)
    );

    assign out_valid          = ovld_reg;
    assign is_monotonic       = omono_reg;
    assign span_percent       = ospan_reg;
    assign run_score          = oscore_reg;
    assign degenerate         = odegen_reg;
    assign lowest_running_rpm = olnz_reg;
    assign final_rpm          = ofinal_reg;
    assign ppr_advice         = oppr_reg;

`ifndef SYNTH
    // The span of a finished sweep never exceeds one hundred percent.
    a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (span_percent <= PCT_FULL))
        else $error("span percent above 100");

    // The score follows the span exactly when monotonic and is zero otherwise.
    a_score_rule: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_score == (is_monotonic ? span_percent : '0)))
        else $error("score inconsistent with span and monotonic flag");

    // A non-monotonic sweep is always degenerate.
    a_degen_rule: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_monotonic) |-> degenerate)
        else $error("non-monotonic sweep not marked degenerate");

    // The suggested ppr stays within one to four.
    a_ppr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ppr_advice >= PPR_LO && ppr_advice <= PPR_HI))
        else $error("suggested ppr out of range");
`endif

endmodule

FILE: tb/fan_sweep_evaluator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fan_sweep_evaluator: drives sweep readings and
// register writes, predicts every sweep report and compares field by field.
// Depends on fse_pkg and the fan_sweep_evaluator RTL only.
module fan_sweep_evaluator_tb;
    import fse_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 25;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic [CIDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // One sweep reading as offered on the input channel
    typedef struct {
        logic [RPM_W-1:0] rpm;
        logic             vld;
        logic             lst;
    } reading_t;

    // One sweep report as expected on the output channel
    typedef struct {
        logic             mono;
        logic [PCT_W-1:0] span;
        logic [PCT_W-1:0] score;
        logic             degen;
        logic [RPM_W-1:0] low_run;
        logic [RPM_W-1:0] fin_rpm;
        logic [PPR_W-1:0] ppr;
    } sweep_report_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [RPM_W-1:0]   sample_rpm = '0;
    logic               reading_valid = 1'b0;
    logic               last_sample = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               is_monotonic;
    logic [PCT_W-1:0]   span_percent;
    logic [PCT_W-1:0]   run_score;
    logic               degenerate;
    logic [RPM_W-1:0]   lowest_running_rpm;
    logic [RPM_W-1:0]   final_rpm;
    logic [PPR_W-1:0]   ppr_advice;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [RPM_W-1:0]   cfg_data = '0;

    // Pending readings and sweep reports still owed by the block
    reading_t      readings_pending[$];
    sweep_report_t reports_due[$];
    reading_t      next_reading;

    // Predicted configuration
    logic [PPR_W-1:0] run_ppr = RST_ASSUMED_PPR;
    logic [PCT_W-1:0] run_tol = RST_MONO_TOL;
    logic [PCT_W-1:0] run_flat = RST_FLAT_MIN_SPAN;
    logic [RPM_W-1:0] run_min = RST_PLAUS_MIN;
    logic [RPM_W-1:0] run_max = RST_PLAUS_MAX;

    // Predicted run state
    logic [RPM_W-1:0] prev_rpm;
    logic [RPM_W-1:0] low_rpm;
    logic [RPM_W-1:0] high_rpm;
    logic [RPM_W-1:0] low_nz_rpm;
    logic             nz_seen;
    logic             mono_ok;
    logic             first_rd;

    // Settings the stimulus generator aims at
    int unsigned gen_tol = RST_MONO_TOL;
    int unsigned gen_min = RST_PLAUS_MIN;
    int unsigned gen_max = RST_PLAUS_MAX;

    // Handshake bookkeeping and idling control
    logic in_taken = 1'b0;
    bit   sending = 1'b0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;
    bit   hold_used = 1'b0;
    int   hold_left = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   cycle_count = 0;
    int   errors = 0;
    int   readings_taken = 0;
    int   reports_checked = 0;
    int   settings_used = 1;

    fan_sweep_evaluator u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .sample_rpm         (sample_rpm),
        .reading_valid      (reading_valid),
        .last_sample        (last_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .is_monotonic       (is_monotonic),
        .span_percent       (span_percent),
        .run_score          (run_score),
        .degenerate         (degenerate),
        .lowest_running_rpm (lowest_running_rpm),
        .final_rpm          (final_rpm),
        .ppr_advice         (ppr_advice),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #10 clk = ~clk;

    // Rearm the predicted run state for a new sweep.
    task automatic clear_run();
        begin
            prev_rpm   = '0;
            low_rpm    = RPM_MAX_VAL;
            high_rpm   = '0;
            low_nz_rpm = RPM_MAX_VAL;
            nz_seen    = 1'b0;
            mono_ok    = 1'b1;
            first_rd   = 1'b1;
        end
    endtask

    // Mirror one accepted register write in the predicted configuration.
    task automatic apply_setting(input logic [CIDX_W-1:0] idx, input logic [RPM_W-1:0] data);
        begin
            case (idx)
                CFG_ASSUMED_PPR:   run_ppr = data[PPR_W-1:0];
                CFG_MONO_TOL:      run_tol = data[PCT_W-1:0];
                CFG_FLAT_MIN_SPAN: run_flat = data[PCT_W-1:0];
                CFG_PLAUS_MIN:     run_min = data;
                CFG_PLAUS_MAX:     run_max = data;
                default:           ;
            endcase
        end
    endtask

    // Fold one accepted reading into the run; on the last one, queue the report.
    task automatic score_reading(input logic [RPM_W-1:0] raw, input logic vld,
                                 input logic lst);
        int unsigned rpm, tol, floor_v, hi, lo, span, ppr, sugg;
        sweep_report_t rep;
        begin
            rpm = vld ? raw : 0;
            tol = (run_tol > PCT_FULL) ? PCT_FULL : run_tol;
            if (!first_rd)
            begin
                floor_v = (32'(prev_rpm) * (32'(PCT_FULL) - tol)) / 32'(PCT_FULL);
                if (rpm < floor_v)
                    mono_ok = 1'b0;
            end
            if (rpm < low_rpm)
                low_rpm = rpm[RPM_W-1:0];
            if (rpm > high_rpm)
                high_rpm = rpm[RPM_W-1:0];
            if (rpm > 0 && (!nz_seen || rpm < low_nz_rpm))
            begin
                low_nz_rpm = rpm[RPM_W-1:0];
                nz_seen = 1'b1;
            end
            prev_rpm = rpm[RPM_W-1:0];
            first_rd = 1'b0;

            if (lst)
            begin
                hi = high_rpm;
                lo = low_rpm;
                span = (hi == 0) ? 0 : ((hi - lo) * 100) / hi;
                ppr = run_ppr;
                if (ppr < PPR_LO)
                    ppr = PPR_LO;
                if (ppr > PPR_HI)
                    ppr = PPR_HI;
                sugg = ppr;
                if (rpm > run_max)
                begin
                    sugg = ppr * 2;
                    if (sugg > PPR_HI)
                        sugg = PPR_HI;
                end
                else if (rpm > 0 && rpm < run_min)
                begin
                    sugg = ppr / 2;
                    if (sugg < PPR_LO)
                        sugg = PPR_LO;
                end
                rep.mono    = mono_ok;
                rep.span    = span[PCT_W-1:0];
                rep.score   = mono_ok ? span[PCT_W-1:0] : '0;
                rep.degen   = !mono_ok || (span < run_flat);
                rep.low_run = nz_seen ? low_nz_rpm : '0;
                rep.fin_rpm = rpm[RPM_W-1:0];
                rep.ppr     = sugg[PPR_W-1:0];
                reports_due.push_back(rep);
                clear_run();
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        end
    endtask

    // Compare one report transaction with the oldest expected report.
    task automatic check_report();
        sweep_report_t rep;
        begin
            if (reports_due.size() == 0)
            begin
                $display("%0t: report with nothing expected, expected none, actual final_rpm %0d",
                         $time, final_rpm);
                errors++;
            end
            else
            begin
                rep = reports_due.pop_front();
                check_field("is_monotonic", rep.mono, is_monotonic);
                check_field("span_percent", rep.span, span_percent);
                check_field("run_score", rep.score, run_score);
                check_field("degenerate", rep.degen, degenerate);
                check_field("lowest_running_rpm", rep.low_run, lowest_running_rpm);
                check_field("final_rpm", rep.fin_rpm, final_rpm);
                check_field("ppr_advice", rep.ppr, ppr_advice);
                reports_checked++;
            end
        end
    endtask

    task automatic push_reading(input int unsigned rpm, input logic vld, input logic lst);
        reading_t rd;
        begin
            rd.rpm = rpm[RPM_W-1:0];
            rd.vld = vld;
            rd.lst = lst;
            readings_pending.push_back(rd);
        end
    endtask

    // One sweep: mostly rising with random steps, with drops around the
    // tolerance floor, wild readings, invalid readings and finals near the
    // plausibility thresholds.
    task automatic add_run(input int len);
        int unsigned cur, top, stepmax, r, tol_eff, v;
        int i;
        bit dead;
        logic vld;
        begin
            tol_eff = (gen_tol > 100) ? 100 : gen_tol;
            case ($urandom_range(0, 3))
                0:       top = 65535;
                1:       top = 2000;
                2:       top = 40000;
                default: top = $urandom_range(1, 65535);
            endcase
            cur = $urandom_range(0, top);
            stepmax = top / 8 + 1;
            dead = ($urandom_range(0, 19) == 0);
            for (i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                if (i == 0)
                begin
                    // The first reading keeps its starting speed.
                end
                else if (r < 65)
                begin
                    cur += $urandom_range(0, stepmax);
                end
                else if (r < 77)
                begin
                    // Land one below, on or one above the tolerance floor
                    v = cur * (100 - tol_eff) / 100 + $urandom_range(0, 2);
                    cur = (v > 0) ? v - 1 : 0;
                end
                else if (r < 90)
                begin
                    cur -= $urandom_range(0, cur * tol_eff / 100);
                end
                else
                begin
                    cur = $urandom_range(0, 65535);
                end
                if (cur > 65535)
                    cur = 65535;
                vld = !dead && ($urandom_range(0, 11) != 0);
                if (i == len - 1 && $urandom_range(0, 3) == 0)
                begin
                    v = ($urandom_range(0, 1) == 0) ? gen_min : gen_max;
                    v = v + $urandom_range(0, 4);
                    v = (v >= 2) ? v - 2 : 0;
                    if (v > 65535)
                        v = 65535;
                    push_reading(v, 1'b1, 1'b1);
                end
                else
                begin
                    push_reading(cur, vld, i == len - 1);
                end
            end
        end
    endtask

    // Fill the pending queue with roughly count readings, ending on a last one.
    task automatic add_sweeps(input int count, input int short_runs);
        int added, len, before_sz;
        begin
            added = 0;
            while (added < short_runs)
            begin
                before_sz = readings_pending.size();
                add_run($urandom_range(1, 2));
                added += readings_pending.size() - before_sz;
            end
            while (added < count)
            begin
                before_sz = readings_pending.size();
                if ($urandom_range(0, 99) < 85)
                begin
                    case ($urandom_range(0, 9))
                        0:       len = 1;
                        1:       len = $urandom_range(20, 30);
                        default: len = $urandom_range(2, 10);
                    endcase
                    add_run(len);
                end
                else
                begin
                    push_reading($urandom_range(0, 65535), $urandom_range(0, 1),
                                 $urandom_range(0, 3) == 0);
                end
                added += readings_pending.size() - before_sz;
            end
            push_reading($urandom_range(0, 65535), $urandom_range(0, 1), 1'b1);
        end
    endtask

    // Register write transaction; cfg_valid stays high for a following write.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [RPM_W-1:0] data);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!(cfg_valid && cfg_ready));
        end
    endtask

    // Write all five registers; junk fills the bits above the narrow registers' widths at random.
    task automatic program_sweep(input int unsigned ppr_v, input int unsigned tol_v,
                                 input int unsigned flat_v, input int unsigned min_v,
                                 input int unsigned max_v, input bit junk);
        logic [RPM_W-1:0] hi_bits;
        begin
            hi_bits = junk ? RPM_W'($urandom) : '0;
            write_reg(CFG_ASSUMED_PPR, {hi_bits[RPM_W-1:PPR_W], ppr_v[PPR_W-1:0]});
            write_reg(CFG_MONO_TOL, {hi_bits[RPM_W-1:PCT_W], tol_v[PCT_W-1:0]});
            write_reg(CFG_FLAT_MIN_SPAN, {hi_bits[RPM_W-1:PCT_W], flat_v[PCT_W-1:0]});
            write_reg(CFG_PLAUS_MIN, min_v[RPM_W-1:0]);
            write_reg(CFG_PLAUS_MAX, max_v[RPM_W-1:0]);
            @(negedge clk);
            cfg_valid <= 1'b0;
            gen_tol = tol_v[PCT_W-1:0];
            gen_min = min_v[RPM_W-1:0];
            gen_max = max_v[RPM_W-1:0];
            settings_used++;
        end
    endtask

    // Wait until every reading is in and every report is out, then let the
    // block finish any reading that produces no report.
    task automatic wait_drained();
        begin
            do
                @(negedge clk);
            while (sending || readings_pending.size() != 0 || reports_due.size() != 0);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Reading driver: offers queued readings with random idle bursts.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                sending = 1'b0;
                send_gap--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                sending = 1'b0;
                send_gap = $urandom_range(0, 14);
            end
            else if (readings_pending.size() != 0)
            begin
                next_reading = readings_pending.pop_front();
                sample_rpm    <= next_reading.rpm;
                reading_valid <= next_reading.vld;
                last_sample   <= next_reading.lst;
                in_valid      <= 1'b1;
                sending = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
                sending = 1'b0;
            end
        end
    end

    // Report receiver: random stall bursts plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                recv_gap = $urandom_range(0, 14);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: every accepted transaction on the three channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                score_reading(sample_rpm, reading_valid, last_sample);
                readings_taken++;
            end
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
                check_report();
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clear_run();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sweeps under the reset configuration
        push_reading(1000, 1'b1, 1'b1);
        push_reading(5000, 1'b0, 1'b0);
        push_reading(65535, 1'b0, 1'b1);
        push_reading(65535, 1'b1, 1'b1);
        push_reading(0, 1'b1, 1'b0);
        push_reading(1000, 1'b1, 1'b0);
        push_reading(2000, 1'b1, 1'b0);
        push_reading(65535, 1'b1, 1'b1);
        push_reading(10000, 1'b1, 1'b0);
        push_reading(9699, 1'b1, 1'b0);
        push_reading(12000, 1'b1, 1'b1);
        push_reading(10000, 1'b1, 1'b0);
        push_reading(9700, 1'b1, 1'b0);
        push_reading(11000, 1'b1, 1'b1);
        push_reading(100, 1'b1, 1'b0);
        push_reading(150, 1'b1, 1'b0);
        push_reading(250, 1'b1, 1'b1);
        push_reading(30000, 1'b1, 1'b1);
        push_reading(30001, 1'b1, 1'b1);
        push_reading(300, 1'b1, 1'b1);
        push_reading(299, 1'b1, 1'b1);
        push_reading(5000, 1'b1, 1'b0);
        push_reading(7000, 1'b0, 1'b0);
        push_reading(8000, 1'b1, 1'b1);
        push_reading(0, 1'b1, 1'b0);
        push_reading(0, 1'b1, 1'b1);
        wait_drained();

        // Zero tolerance and flat threshold, widest plausibility range: no drop allowed, never flat
        program_sweep(1, 0, 0, 0, 65535, 1'b0);
        add_sweeps(250, 0);
        wait_drained();

        // Opposite extremes, with a long report stall while readings keep coming
        program_sweep(4, 100, 100, 65535, 0, 1'b0);
        hold_req = 1'b1;
        add_sweeps(250, 80);
        wait_drained();

        // Tolerance and flat threshold beyond 100, ppr of zero, unused index
        program_sweep(0, 127, 127, 1000, 20000, 1'b0);
        write_reg(CFG_UNUSED_IDX, RPM_W'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        add_sweeps(250, 0);
        wait_drained();

        // Top ppr code, moderate tolerance
        program_sweep(7, 10, 50, 300, 30000, 1'b0);
        add_sweeps(250, 0);
        wait_drained();

        // Random settings, with stray bits above the narrow registers
        program_sweep($urandom_range(5, 6), $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1);
        add_sweeps(250, 0);
        wait_drained();

        // Closing stretch at full rate on both sides
        program_sweep(3, 5, 20, 500, 40000, 1'b0);
        quiet = 1'b1;
        add_sweeps(280, 0);
        wait_drained();

        $display("Run covered %0d readings and %0d sweep reports over %0d register settings,",
                 readings_taken, reports_checked, settings_used);
        $display("including ppr clamping, threshold extremes and a long report stall.");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fse_pkg.sv
rtl/fse_arith.sv
rtl/fan_sweep_evaluator.sv
tb/fan_sweep_evaluator_tb.sv
